### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CHK_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bba_pkg.sv
// types and codes of the buddy block allocator
package bba_pkg;

  localparam int MEM_ORDER = 10;
  localparam int ADDR_W    = MEM_ORDER;
  localparam int ORDER_W   = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UL_RD,
    S_UL_WR,
    S_SPLIT,
    S_AP1,
    S_AP2,
    S_FR_CHK,
    S_BD_RD,
    S_BD_CHK,
    S_DONE
  } state_t;

endpackage

### rtl/buddy_block_allocator_unit.sv
// buddy block allocator: free lists per order, link and mark memories, sequencer
//
// A request is taken when start is high and busy is low. Each request gives
// exactly one result beat on out_strobe, one cycle wide; the receiver cannot
// stall, so it must take the beat in that cycle. After reset the block runs a
// clearing pass over every unit of the link and mark memories with busy high.
// A bad order, or a bad address on a free, is rejected at once, and a free of
// a unit that already heads a free block after its mark is read. An allocate
// scans the orders upward from the requested one and either reports
// exhaustion or unlinks the block found and splits it down level by level; a
// free merges with its buddy level by level until the buddy is not free at
// that order or the top order is reached. Busy drops in the result cycle, so
// the next request can be taken there. The split and merge walk sets the worst
// case, with one read-modify-write of the link and mark memories (one read and
// one write port each) per step.
module buddy_block_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [bba_pkg::ORDER_W-1:0] in_order,
  input  logic [bba_pkg::ADDR_W-1:0]  in_address,
  output logic                        out_strobe,
  output logic [bba_pkg::ADDR_W-1:0]  out_address_res,
  output logic [1:0]                  out_status
);
  import bba_pkg::*;

  // unit index, link word (one extra bit for the empty code), order and list index
  localparam int UW     = MEM_ORDER;
  localparam int LW     = MEM_ORDER + 1;
  localparam int OW     = $clog2(MEM_ORDER + 2);
  localparam int HIW    = $clog2(MEM_ORDER + 1);
  localparam int NUNITS = 1 << MEM_ORDER;
  localparam logic [LW-1:0] NIL     = LW'(NUNITS);
  localparam logic [OW-1:0] TOP_ORD = OW'(MEM_ORDER);

  state_t state_r, state_nxt;

  logic          op_r;
  logic [OW-1:0] s_r;      // requested order
  logic [OW-1:0] k_r;      // order being worked on
  logic [UW-1:0] p_r;      // block base (allocated head or merged block)
  logic [UW-1:0] u_r;      // unit under unlink or append
  logic [LW-1:0] t_r;      // old tail during append
  logic [UW-1:0] res_r;
  logic [1:0]    stat_r;
  logic [UW-1:0] clr_r;

  logic                out_strobe_r;
  logic [ADDR_W-1:0]   out_address_res_r;
  logic [1:0]          out_status_r;

  // free list heads and tails, one per order
  logic [LW-1:0] head_r [0:MEM_ORDER];
  logic [LW-1:0] tail_r [0:MEM_ORDER];

  // per-unit memories
  logic [LW-1:0] next_mem [0:NUNITS-1];
  logic [LW-1:0] prev_mem [0:NUNITS-1];
  logic [OW-1:0] mark_mem [0:NUNITS-1];
  logic [LW-1:0] nx_q, pv_q;
  logic [OW-1:0] mk_q;

  // memory and list port controls
  logic          nx_we, pv_we, mk_we, hd_we, tl_we;
  logic [UW-1:0] nx_wa, pv_wa, mk_wa, lk_ra, mk_ra;
  logic [LW-1:0] nx_wd, pv_wd, hd_wd, tl_wd;
  logic [OW-1:0] mk_wd;

  logic [HIW-1:0] kidx;
  logic [LW-1:0]  hd_k, tl_k;
  logic [OW-1:0]  km1, kp1;
  logic [UW-1:0]  kbit, kbit_m1, buddy;
  logic           accept, ord_bad, addr_bad;

  // shared order arithmetic on k_r: list lookup, k-1 and k+1, unit bits and buddy index
  assign kidx    = k_r[HIW-1:0];
  assign hd_k    = head_r[kidx];
  assign tl_k    = tail_r[kidx];
  assign km1     = k_r - OW'(1);
  assign kp1     = k_r + OW'(1);
  assign kbit    = UW'(1) << k_r;
  assign kbit_m1 = UW'(1) << km1;
  assign buddy   = p_r ^ kbit;

  assign accept   = start && (state_r == S_IDLE);
  assign ord_bad  = 32'(in_order) > MEM_ORDER;
  assign addr_bad = (32'(in_address) >= NUNITS) ||
                    ((32'(in_address) & ((32'd1 << in_order) - 32'd1)) != 32'd0);

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_address_res = out_address_res_r;
  assign out_status      = out_status_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_r == {UW{1'b1}}) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (ord_bad)                 state_nxt = S_DONE;
          else if (in_opcode == OP_ALLOC) state_nxt = S_SCAN;
          else if (addr_bad)           state_nxt = S_DONE;
          else                         state_nxt = S_FR_CHK;
        end
      end
      S_SCAN: begin
        if (k_r > TOP_ORD)   state_nxt = S_DONE;
        else if (hd_k != NIL) state_nxt = S_UL_RD;
      end
      S_UL_RD:  state_nxt = S_UL_WR;
      S_UL_WR:  state_nxt = (op_r == OP_ALLOC) ? S_SPLIT : S_BD_RD;
      S_SPLIT:  state_nxt = (k_r == s_r) ? S_DONE : S_AP1;
      S_AP1:    state_nxt = S_AP2;
      S_AP2:    state_nxt = (op_r == OP_ALLOC) ? S_SPLIT : S_DONE;
      S_FR_CHK: state_nxt = (mk_q != '0) ? S_DONE : S_BD_RD;
      S_BD_RD:  state_nxt = (k_r == TOP_ORD) ? S_AP1 : S_BD_CHK;
      S_BD_CHK: state_nxt = (mk_q == kp1) ? S_UL_RD : S_AP1;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory and list write controls
  always_comb begin
    nx_we = 1'b0; nx_wa = u_r; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = u_r; pv_wd = NIL;
    mk_we = 1'b0; mk_wa = u_r; mk_wd = '0;
    hd_we = 1'b0; hd_wd = NIL;
    tl_we = 1'b0; tl_wd = NIL;
    lk_ra = u_r;
    mk_ra = (state_r == S_IDLE) ? UW'(in_address) : buddy;
    case (state_r)
      S_CLEAR: begin
        nx_we = 1'b1; nx_wa = clr_r;
        pv_we = 1'b1; pv_wa = clr_r;
        mk_we = 1'b1; mk_wa = clr_r;
        mk_wd = (clr_r == '0) ? OW'(MEM_ORDER + 1) : '0;
      end
      S_UL_WR: begin
        // unlink u_r from the list of order k_r
        mk_we = 1'b1;
        if (pv_q != NIL) begin
          nx_we = 1'b1; nx_wa = pv_q[UW-1:0]; nx_wd = nx_q;
        end else begin
          hd_we = 1'b1; hd_wd = nx_q;
        end
        if (nx_q != NIL) begin
          pv_we = 1'b1; pv_wa = nx_q[UW-1:0]; pv_wd = pv_q;
        end else begin
          tl_we = 1'b1; tl_wd = pv_q;
        end
      end
      S_AP1: begin
        // append u_r at the tail of order k_r
        pv_we = 1'b1; pv_wd = tl_k;
        nx_we = 1'b1; nx_wd = NIL;
        mk_we = 1'b1; mk_wd = kp1;
        tl_we = 1'b1; tl_wd = {1'b0, u_r};
        if (tl_k == NIL) begin
          hd_we = 1'b1; hd_wd = {1'b0, u_r};
        end
      end
      S_AP2: begin
        if (t_r != NIL) begin
          nx_we = 1'b1; nx_wa = t_r[UW-1:0]; nx_wd = {1'b0, u_r};
        end
      end
      default: ;
    endcase
  end

  // control registers and free list heads and tails
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i <= MEM_ORDER; i++) begin
        head_r[i] <= (i == MEM_ORDER) ? '0 : NIL;
        tail_r[i] <= (i == MEM_ORDER) ? '0 : NIL;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_DONE);
      if (state_r == S_CLEAR) clr_r <= clr_r + UW'(1);
      if (hd_we) head_r[kidx] <= hd_wd;
      if (tl_we) tail_r[kidx] <= tl_wd;
    end
  end

  // working registers and result beat
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_r  <= in_opcode;
          s_r   <= OW'(in_order);
          k_r   <= OW'(in_order);
          p_r   <= UW'(in_address);
          res_r <= '0;
          if (ord_bad || (in_opcode == OP_FREE && addr_bad)) stat_r <= STAT_BAD;
          else                                                stat_r <= STAT_OK;
        end
      end
      S_SCAN: begin
        if (k_r > TOP_ORD) begin
          stat_r <= STAT_NOSPACE;
        end else if (hd_k == NIL) begin
          k_r <= kp1;
        end else begin
          u_r <= hd_k[UW-1:0];
          p_r <= hd_k[UW-1:0];
        end
      end
      S_UL_WR: begin
        if (op_r == OP_FREE) begin
          p_r <= p_r & ~kbit;
          k_r <= kp1;
        end
      end
      S_SPLIT: begin
        if (k_r == s_r) begin
          res_r <= p_r;
        end else begin
          k_r <= km1;
          u_r <= p_r | kbit_m1;   // upper half of the split block
        end
      end
      S_AP1:    t_r <= tl_k;
      S_FR_CHK: if (mk_q != '0) stat_r <= STAT_BAD;
      S_BD_RD:  u_r <= (k_r == TOP_ORD) ? p_r : buddy;
      S_BD_CHK: if (mk_q != kp1) u_r <= p_r;
      S_DONE: begin
        out_address_res_r <= ADDR_W'(res_r);
        out_status_r      <= stat_r;
      end
      default: ;
    endcase
  end

  // link and mark memories, registered reads
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    nx_q <= next_mem[lk_ra];
    pv_q <= prev_mem[lk_ra];
    mk_q <= mark_mem[mk_ra];
  end

endmodule

### rtl/bba_checker.sv
// port checks of the buddy block allocator and their bind
`include "assert_macros.svh"

module bba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_opcode,
  input logic [bba_pkg::ORDER_W-1:0] in_order,
  input logic [bba_pkg::ADDR_W-1:0]  in_address,
  input logic                        out_strobe,
  input logic [bba_pkg::ADDR_W-1:0]  out_address_res,
  input logic [1:0]                  out_status
);
  import bba_pkg::*;

  `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
  `CHK_NEXT(a_strobe_pulse, clk, rst_n, out_strobe, !out_strobe, "result strobe longer than one cycle")
  `CHK_PROP(a_status_code, clk, rst_n, out_strobe |-> (out_status == STAT_OK || out_status == STAT_NOSPACE || out_status == STAT_BAD), "unknown status code")
  `CHK_PROP(a_err_addr_zero, clk, rst_n, (out_strobe && out_status != STAT_OK) |-> (out_address_res == '0), "failed request returned an address")
  `CHK_PROP(a_strobe_after_busy, clk, rst_n, out_strobe |-> $past(busy), "result without a request in flight")

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (.*);
